// File: src/small_integer_alu_overflow_promote_unit_defines.svh
// Assertion macros for the small-integer ALU.
// Used by the top level only; no other dependencies.
`ifndef SMALL_INTEGER_ALU_OVERFLOW_PROMOTE_UNIT_DEFINES_SVH
`define SMALL_INTEGER_ALU_OVERFLOW_PROMOTE_UNIT_DEFINES_SVH

// Check that a property holds on every clock edge outside reset.
`define SIAOP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check an implication on every clock edge outside reset.
`define SIAOP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// File: src/siaop_pkg.sv
// Types and constants for the small-integer ALU.
// No dependencies.
package siaop_pkg;

  typedef enum logic [2:0] {
    OP_ADD  = 3'd0,
    OP_SUB  = 3'd1,
    OP_MUL  = 3'd2,
    OP_DIV  = 3'd3,
    OP_REM  = 3'd4,
    OP_AND  = 3'd5,
    OP_EQ   = 3'd6,
    OP_LESS = 3'd7
  } op_e;

  localparam int unsigned DataW  = 32;
  localparam int unsigned WideW  = 64;
  // One divider cell per quotient bit.
  localparam int unsigned NumCells = 32;

  localparam logic signed [WideW-1:0] Int32Max = 64'sd2147483647;
  localparam logic signed [WideW-1:0] Int32Min = -64'sd2147483648;

  typedef struct packed {
    logic [2:0]              kind;
    logic signed [DataW-1:0] left_operand;
    logic signed [DataW-1:0] right_operand;
  } in_req_t;

  typedef struct packed {
    logic signed [WideW-1:0] value;
    logic                    needs_promotion;
    logic                    divide_error;
  } out_req_t;

  // Control and data moving down the cell chain.
  typedef struct packed {
    logic                    valid;
    logic [2:0]              kind;
    logic                    neg_quo;   // quotient negative
    logic                    neg_rem;   // remainder negative
    logic                    div_zero;
    logic [DataW:0]          rem;       // partial remainder (magnitude)
    logic [DataW-1:0]        quo;       // shifts in quotient bits, dividend out
    logic [DataW-1:0]        divisor;   // divisor magnitude
    logic signed [WideW-1:0] result;    // finished value for non-divide ops
  } cell_t;

endpackage

// File: src/siaop_cell.sv
// One chain cell: a restoring divide step on one quotient bit, passing the
// request to the next cell. Depends on siaop_pkg.
module siaop_cell import siaop_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  adv_i,
  input  cell_t prev_i,
  output cell_t cell_o
);

  cell_t          cell_d, cell_q;
  logic           valid_q;
  logic [DataW:0] trial;
  logic [DataW+1:0] diff;

  // Shift in one dividend bit and try the subtract.
  always_comb begin
    cell_d = prev_i;
    trial  = {prev_i.rem[DataW-1:0], prev_i.quo[DataW-1]};
    diff   = {1'b0, trial} - {2'b00, prev_i.divisor};
    if (!diff[DataW+1]) begin
      cell_d.rem = diff[DataW:0];
      cell_d.quo = {prev_i.quo[DataW-2:0], 1'b1};
    end else begin
      cell_d.rem = trial;
      cell_d.quo = {prev_i.quo[DataW-2:0], 1'b0};
    end
  end

  // Advance valid under reset; payload needs none.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= cell_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      cell_q <= cell_d;
    end
  end

  // Merge the reset valid bit with the payload.
  always_comb begin
    cell_o       = cell_q;
    cell_o.valid = valid_q;
  end

endmodule

// File: src/siaop_front.sv
// Entry stage: decode the request, run the add, subtract, AND and compare operations and the
// 32x32 multiply, and set up the divider operands. Depends on siaop_pkg.
module siaop_front import siaop_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    adv_i,
  input  logic    valid_i,
  input  in_req_t req_i,
  output cell_t   cell_o
);

  cell_t                   cell_d, cell_q;
  logic                    valid_q;
  logic signed [WideW-1:0] a_w, b_w;
  logic [DataW-1:0]        a_mag, b_mag;
  op_e                     op;

  // Form simple results and divider setup.
  always_comb begin
    op    = op_e'(req_i.kind);
    a_w   = WideW'(req_i.left_operand);
    b_w   = WideW'(req_i.right_operand);
    a_mag = req_i.left_operand[DataW-1] ? (~req_i.left_operand + 1'b1)
                                        : req_i.left_operand;
    b_mag = req_i.right_operand[DataW-1] ? (~req_i.right_operand + 1'b1)
                                         : req_i.right_operand;
    cell_d          = '0;
    cell_d.valid    = valid_i;
    cell_d.kind     = req_i.kind;
    cell_d.neg_quo  = req_i.left_operand[DataW-1] ^ req_i.right_operand[DataW-1];
    cell_d.neg_rem  = req_i.left_operand[DataW-1];
    cell_d.div_zero = (req_i.right_operand == '0);
    cell_d.quo      = a_mag;
    cell_d.divisor  = b_mag;
    unique case (op)
      OP_ADD:  cell_d.result = a_w + b_w;
      OP_SUB:  cell_d.result = a_w - b_w;
      OP_MUL:  cell_d.result = a_w * b_w;
      OP_AND:  cell_d.result = a_w & b_w;
      OP_EQ:   cell_d.result = WideW'(req_i.left_operand == req_i.right_operand);
      OP_LESS: cell_d.result = WideW'(req_i.left_operand < req_i.right_operand);
      default: cell_d.result = '0;
    endcase
  end

  // Hold valid under reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= cell_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      cell_q <= cell_d;
    end
  end

  // Merge the reset valid bit with the payload.
  always_comb begin
    cell_o       = cell_q;
    cell_o.valid = valid_q;
  end

endmodule

// File: src/small_integer_alu_overflow_promote_unit.sv
// Small-integer ALU with 64-bit exact results and promotion flag.
// Pipeline from accepted request to result valid: entry stage,
// 32 divider cells, sign-fix stage, output register. Throughput: one
// request per cycle; the whole chain advances together unless the output
// is stalled while full. Reset clears all valid bits; no other state.
// Depends on siaop_pkg and the defines header.
`include "small_integer_alu_overflow_promote_unit_defines.svh"
module small_integer_alu_overflow_promote_unit import siaop_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_req_t  in_req_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output out_req_t out_req_o
);

  cell_t                   chain [NumCells+1];
  logic                    adv;
  logic                    fix_valid_q;
  logic [2:0]              fix_kind_q;
  logic                    fix_dz_q;
  logic signed [WideW-1:0] fix_val_q;
  logic signed [WideW-1:0] fix_val_d;
  logic [DataW-1:0]        quo_fin;
  logic [DataW:0]          rem_fin;
  out_req_t                out_d, out_q;
  logic                    out_valid_q;

  // Advance everything when the output slot is free or being taken.
  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = !adv;

  siaop_front u_front (
    .clk_i, .rst_ni, .adv_i(adv), .valid_i(in_valid_i), .req_i(in_req_i),
    .cell_o(chain[0])
  );

  for (genvar g = 0; g < NumCells; g++) begin : g_cell
    siaop_cell u_cell (
      .clk_i, .rst_ni, .adv_i(adv), .prev_i(chain[g]), .cell_o(chain[g+1])
    );
  end

  // Apply signs to the divider result; other operations pass their result through.
  always_comb begin
    quo_fin = chain[NumCells].quo;
    rem_fin = chain[NumCells].rem;
    unique case (op_e'(chain[NumCells].kind))
      OP_DIV: fix_val_d = chain[NumCells].neg_quo
                ? -$signed({32'd0, quo_fin}) : $signed({32'd0, quo_fin});
      OP_REM: fix_val_d = chain[NumCells].neg_rem
                ? -$signed({31'd0, rem_fin}) : $signed({31'd0, rem_fin});
      default: fix_val_d = chain[NumCells].result;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fix_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      fix_valid_q <= chain[NumCells].valid;
      out_valid_q <= fix_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      fix_kind_q <= chain[NumCells].kind;
      fix_dz_q   <= chain[NumCells].div_zero;
      fix_val_q  <= fix_val_d;
      out_q      <= out_d;
    end
  end

  // Drop the value on a zero divisor and flag range overflow.
  always_comb begin
    out_d = '0;
    if ((op_e'(fix_kind_q) == OP_DIV || op_e'(fix_kind_q) == OP_REM) && fix_dz_q) begin
      out_d.divide_error = 1'b1;
    end else begin
      out_d.value           = fix_val_q;
      out_d.needs_promotion = (fix_val_q > Int32Max) || (fix_val_q < Int32Min);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

  `SIAOP_ASSERT_IMP(a_err_zero, out_valid_o && out_req_o.divide_error,
    out_req_o.value == '0 && !out_req_o.needs_promotion, "divide error with nonzero value")
  `SIAOP_ASSERT_IMP(a_hold, out_valid_o && out_stall_i, ##1 out_valid_o && $stable(out_req_o),
    "stalled result changed")
  `SIAOP_ASSERT(a_stall_link, in_stall_o == (out_valid_o && out_stall_i),
    "input stall not tied to output stall")

endmodule
